// ===== rtl/ccrc_pkg.sv =====
// ccrc_pkg: shared types, register indexes and helper functions for the
// configurable crc-16 block. no dependencies.
package ccrc_pkg;

  localparam int CRC_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOP    = 16'h8000;
  localparam logic [CRC_W-1:0] CRC_BOTTOM = 16'h0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_VALUE     = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_FINAL_XOR      = 3'd2,
    REG_REFLECT_INPUT  = 3'd3,
    REG_REFLECT_OUTPUT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CRC_W-1:0] init_value;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] final_xor;
    logic             reflect_input;
    logic             reflect_output;
  } crc_cfg_t;

  function automatic logic [CRC_W-1:0] bit_reverse16(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int k = 0; k < CRC_W; k++) begin
      r[k] = v[CRC_W-1-k];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ccrc_absorb.sv =====
// ccrc_absorb: folds one byte into the running crc, eight unrolled shift
// steps, and forms the finished crc for a last byte. uses ccrc_pkg.
module ccrc_absorb import ccrc_pkg::*; (
  input  crc_cfg_t          cfg,
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data_byte,
  output logic [CRC_W-1:0]  crc_next,
  output logic [CRC_W-1:0]  crc_final
);

  logic [CRC_W-1:0] rpoly;
  logic [CRC_W-1:0] c;

  assign rpoly = bit_reverse16(cfg.polynomial);

  always_comb begin
    if (!cfg.reflect_input) begin
      c = crc_in ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
        if ((c & CRC_TOP) != '0) begin
          c = {c[CRC_W-2:0], 1'b0} ^ cfg.polynomial;
        end else begin
          c = {c[CRC_W-2:0], 1'b0};
        end
      end
    end else begin
      c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
      for (int k = 0; k < BYTE_W; k++) begin
        if ((c & CRC_BOTTOM) != '0) begin
          c = {1'b0, c[CRC_W-1:1]} ^ rpoly;
        end else begin
          c = {1'b0, c[CRC_W-1:1]};
        end
      end
    end
  end

  assign crc_next = c;

  // reversal needed whenever the two reflection settings disagree
  assign crc_final = ((cfg.reflect_input != cfg.reflect_output) ? bit_reverse16(c) : c)
                     ^ cfg.final_xor;

endmodule

// ===== rtl/configurable_crc16.sv =====
// configurable_crc16: top level of the configurable crc-16 block.
// depends on ccrc_pkg and ccrc_absorb.
//
// usage:
//   in_*  : byte stream, one message byte per request; in_tlast marks the
//           final byte of a message. every message has at least one byte.
//   out_* : one request per message carrying the finished crc, issued after
//           the last byte, reflection and final xor.
//   cfg_* : write port for init_value (0), polynomial (1), final_xor (2),
//           reflect_input (3) and reflect_output (4). a write to any of these
//           reloads the running crc from init_value; other indexes do nothing.
//           write only while no message is in flight.
// timing:
//   one byte per cycle while in_tready is high. the byte update is eight unrolled shift
//   steps of xor logic feeding the crc register directly, so the crc of a
//   message appears on out_* in the cycle after its last byte is accepted.
// reset:
//   registers return to init 0, polynomial 0x1021, final xor 0, no
//   reflection; the running crc is 0 and the output is empty.
// stalls:
//   the output register holds one crc; input is taken whenever that register
//   is empty or is being drained in the same cycle, so a stalled receiver
//   blocks input only while a finished crc waits.
module configurable_crc16 import ccrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // last_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [CRC_W-1:0]     out_tdata,  // [15:0] crc_value
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_wdata
);

  crc_cfg_t         cfg_r, cfg_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0] upd_next, upd_final;
  logic             in_acc, cfg_hit;

  ccrc_absorb u_absorb (
    .cfg       (cfg_r),
    .crc_in    (crc_r),
    .data_byte (in_tdata),
    .crc_next  (upd_next),
    .crc_final (upd_final)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    cfg_nxt = cfg_r;
    cfg_hit = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INIT_VALUE: begin
          cfg_nxt.init_value = cfg_wdata;
          cfg_hit = 1'b1;
        end
        REG_POLYNOMIAL: begin
          cfg_nxt.polynomial = cfg_wdata;
          cfg_hit = 1'b1;
        end
        REG_FINAL_XOR: begin
          cfg_nxt.final_xor = cfg_wdata;
          cfg_hit = 1'b1;
        end
        REG_REFLECT_INPUT: begin
          cfg_nxt.reflect_input = cfg_wdata[0];
          cfg_hit = 1'b1;
        end
        REG_REFLECT_OUTPUT: begin
          cfg_nxt.reflect_output = cfg_wdata[0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    crc_nxt       = crc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cfg_hit) begin
      crc_nxt = cfg_nxt.init_value;
    end else if (in_acc) begin
      if (in_tlast) begin
        crc_nxt       = cfg_r.init_value;
        out_data_nxt  = upd_final;
        out_valid_nxt = 1'b1;
      end else begin
        crc_nxt = upd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_value     <= '0;
      cfg_r.polynomial     <= POLY_RESET;
      cfg_r.final_xor      <= '0;
      cfg_r.reflect_input  <= 1'b0;
      cfg_r.reflect_output <= 1'b0;
      crc_r                <= '0;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // a last byte taken without a config write always leaves a crc waiting next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast && !cfg_wr_en |=> out_tvalid)
    else $error("last byte accepted but no crc pending");

  // a middle byte never creates a result of its own
  a_mid_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tlast && !cfg_wr_en |=> out_tvalid == $past(out_valid_r && !out_tready))
    else $error("result appeared for a non-last byte");

  // running crc restarts from init_value after a message ends
  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast && !cfg_wr_en |=> crc_r == cfg_r.init_value)
    else $error("crc register not reloaded after last byte");

  // input must be refused while a crc waits on a stalled receiver
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while output is stalled");

endmodule

// ===== test/crc_monitor.sv =====
`timescale 1ns / 100ps
// crc_monitor: watches the config port and both streams of configurable_crc16,
// keeps its own crc state, predicts every finished crc and compares it.
// depends on ccrc_pkg.
module crc_monitor import ccrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [CRC_W-1:0]     out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_wdata,
  output int                   crc_fail_count,
  output int                   crc_pending,
  output int                   crcs_checked
);

  localparam int MAX_REPORTS = 40;

  logic [CRC_W-1:0] seed_crc;
  logic [CRC_W-1:0] gen_poly;
  logic [CRC_W-1:0] xor_out;
  logic             refl_in;
  logic             refl_out;
  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] expected_crcs[$];
  int               errors = 0;
  int               compared = 0;

  function automatic logic [CRC_W-1:0] mirror16(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int k = 0; k < CRC_W; k++) r[CRC_W-1-k] = v[k];
    return r;
  endfunction

  // eight shift steps, msb-first normally, lsb-first with the mirrored polynomial
  function automatic logic [CRC_W-1:0] crc_absorb(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic [CRC_W-1:0] poly,
                                                  input logic lsb_first);
    logic [CRC_W-1:0] c;
    logic [CRC_W-1:0] rpoly;
    c = crc;
    rpoly = mirror16(poly);
    if (!lsb_first) begin
      c = c ^ {data, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) c = c[CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
    end else begin
      c = c ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    end
    return c;
  endfunction

  always @(posedge clk) begin : track
    logic [CRC_W-1:0] next_crc;
    logic [CRC_W-1:0] want;
    logic             known_reg;
    if (!rst_n) begin
      seed_crc = '0;
      gen_poly = POLY_RESET;
      xor_out = '0;
      refl_in = 1'b0;
      refl_out = 1'b0;
      running_crc = '0;
      expected_crcs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_crcs.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: crc request with none expected, actual %h", $time, out_tdata);
        end else begin
          want = expected_crcs.pop_front();
          compared++;
          if (out_tdata !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: crc mismatch, expected %h, actual %h", $time, want, out_tdata);
          end
        end
      end

      if (cfg_wr_en) begin
        known_reg = 1'b1;
        case (cfg_index)
          REG_INIT_VALUE:     seed_crc = cfg_wdata;
          REG_POLYNOMIAL:     gen_poly = cfg_wdata;
          REG_FINAL_XOR:      xor_out = cfg_wdata;
          REG_REFLECT_INPUT:  refl_in = cfg_wdata[0];
          REG_REFLECT_OUTPUT: refl_out = cfg_wdata[0];
          default:            known_reg = 1'b0;
        endcase
        if (known_reg) running_crc = seed_crc;
      end

      if (in_tvalid && in_tready) begin
        next_crc = crc_absorb(running_crc, in_tdata, gen_poly, refl_in);
        if (in_tlast) begin
          if (refl_in != refl_out) next_crc = mirror16(next_crc);
          expected_crcs.push_back(next_crc ^ xor_out);
          running_crc = seed_crc;
        end else begin
          running_crc = next_crc;
        end
      end
    end
    crc_fail_count <= errors;
    crc_pending <= expected_crcs.size();
    crcs_checked <= compared;
  end

endmodule

// ===== test/configurable_crc16_tb.sv =====
`timescale 1ns / 100ps
// configurable_crc16_tb: drives byte messages and crc settings into
// configurable_crc16 and gives the verdict; checking lives in crc_monitor.
module configurable_crc16_tb;
  import ccrc_pkg::*;

  localparam int BYTE_TARGET = 1675;
  localparam int SETTLE_CYCLES = 4;
  localparam int FIRST_UNUSED_IDX = REG_REFLECT_OUTPUT + 1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CRC_W-1:0]     out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CRC_W-1:0]     cfg_wdata = '0;

  int crc_fail_count;
  int crc_pending;
  int crcs_checked;
  int in_gap_max = 0;
  int out_stall_max = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int settings_used = 0;

  configurable_crc16 uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  crc_monitor u_crc_monitor (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .crc_fail_count(crc_fail_count), .crc_pending(crc_pending), .crcs_checked(crcs_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one message byte per request, random hold-off before each
  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (last) msgs_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) push_byte(BYTE_W'($urandom), i == len - 1);
  endtask

  // wait until every crc has come out, then let the outputs settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (crc_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_wr_en high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_crc(input logic [CRC_W-1:0] init, input logic [CRC_W-1:0] poly,
                         input logic [CRC_W-1:0] fxor, input logic refin, input logic refout);
    drain();
    write_reg(REG_INIT_VALUE, init);
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_FINAL_XOR, fxor);
    // junk in the upper bits of the one-bit registers must be dropped
    write_reg(REG_REFLECT_INPUT, {15'($urandom), refin});
    write_reg(REG_REFLECT_OUTPUT, {15'($urandom), refout});
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic write_unused_regs();
    drain();
    for (int k = FIRST_UNUSED_IDX; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CRC_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int w;
      w = $urandom_range(0, out_stall_max);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    string check_str;
    int    kind;
    int    len;
    check_str = "123456789";
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // reset settings: single-byte extremes, the standard check string, mixed bits, unused indexes
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < check_str.len(); i++)
      push_byte(check_str[i], i == check_str.len() - 1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    write_unused_regs();
    push_byte(8'h31, 1'b1);

    // extreme settings and all four reflection combinations
    set_crc(16'hFFFF, 16'h1021, 16'h0000, 1'b0, 1'b0);
    send_message(2);
    set_crc(16'h0000, 16'h8005, 16'h0000, 1'b1, 1'b1);
    send_message(2);
    set_crc(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_message(1);
    set_crc(16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
    send_message(2);

    while (bytes_sent < BYTE_TARGET) begin
      kind = $urandom_range(0, 7);
      case (kind)
        0:       set_crc(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'($urandom), 1'($urandom));
        1:       set_crc(16'h0000, 16'h0000, 16'h0000, 1'($urandom), 1'($urandom));
        default: set_crc(CRC_W'($urandom), CRC_W'($urandom), CRC_W'($urandom),
                         1'($urandom), 1'($urandom));
      endcase
      if ($urandom_range(0, 9) == 0) write_unused_regs();
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      repeat ($urandom_range(1, 8)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        send_message(len);
      end
    end

    drain();
    $display("%0d bytes in %0d messages over %0d crc settings, %0d crcs compared",
             bytes_sent, msgs_sent, settings_used, crcs_checked);
    if (crc_fail_count == 0 && crc_pending == 0) begin
      $display("configurable_crc16 test passed");
    end else begin
      $display("configurable_crc16 test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d crcs outstanding", crc_pending);
    $display("configurable_crc16 test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ccrc_pkg.sv
rtl/ccrc_absorb.sv
rtl/configurable_crc16.sv
test/crc_monitor.sv
test/configurable_crc16_tb.sv
